// ----- hw/rtl/sst_pkg.sv -----
// shared types and protocol constants for the syn source tracker
`default_nettype none
package sst_pkg;

  // ethernet / ipv4 / tcp field values
  localparam logic [15:0] TYPE_IPV4      = 16'h0800;
  localparam logic [15:0] TYPE_ARP       = 16'h0806;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [5:0]  FLAGS_SYN_ONLY = 6'h02;

  // byte offsets within the frame, counted from the destination address
  localparam int POS_W = 7;
  localparam logic [POS_W-1:0] POS_MAX        = 7'd127;
  localparam logic [POS_W-1:0] POS_TYPE_HI    = 7'd12;
  localparam logic [POS_W-1:0] POS_TYPE_LO    = 7'd13;
  localparam logic [POS_W-1:0] POS_IHL        = 7'd14;
  localparam logic [POS_W-1:0] POS_PROTO      = 7'd23;
  localparam logic [POS_W-1:0] POS_SRC_FIRST  = 7'd26;
  localparam logic [POS_W-1:0] POS_SRC_LAST   = 7'd29;
  // tcp flags sit at 14 + 4 * ihl + 13
  localparam logic [POS_W-1:0] POS_FLAGS_BASE = 7'd27;
  localparam logic [3:0]       IHL_MIN        = 4'd5;

  // frame record queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  // classified frame handed from the parser to the lookup side
  typedef struct packed {
    logic        syn;
    logic        arp;
    logic [31:0] src;
  } frame_rec_t;

endpackage
`default_nettype wire

// ----- hw/rtl/syn_source_tracker.sv -----
// top level: frame parser, record queue and source lookup
//
//   channel  handshake       payload
//   input    push / full     data_byte, last_byte
//   result   empty / pop     syn_seen, arp_seen, new_source, table_full,
//                            syn_total, arp_total, distinct_total
//
// the parser takes one byte beat per cycle and emits a record on the last beat.
// the back end moves a non-syn frame straight to its result; a pure syn frame
// first scans the filled table entries one after another, then gives its result.
// full rises only while four frame records wait in the queue between the two.
// rst is synchronous; the address table needs no clearing pass, entries past
// the fill count are never used.
// a held result (empty low, pop low) stalls the back end; once four records
// wait, full stalls the parser as well
`default_nettype none
module syn_source_tracker
  import sst_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic             syn_seen,
  output logic             arp_seen,
  output logic             new_source,
  output logic             table_full,
  output logic [31:0]      syn_total,
  output logic [31:0]      arp_total,
  output logic [6:0]       distinct_total
);

  logic       beat;
  frame_rec_t front_rec;
  logic       front_push;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;
  frame_rec_t head_rec;

  // input beat accepted while the queue has room
  always_comb begin
    full = q_full;
    beat = push && !q_full;
  end

  sst_front u_front (
    .clk       (clk),
    .rst       (rst),
    .beat      (beat),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .rec       (front_rec),
    .rec_push  (front_push)
  );

  sst_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (front_push),
    .push_rec (front_rec),
    .full     (q_full),
    .pop      (q_pop),
    .head_rec (head_rec),
    .empty    (q_empty)
  );

  sst_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .rec_empty      (q_empty),
    .rec_in         (head_rec),
    .rec_pop        (q_pop),
    .empty          (empty),
    .pop            (pop),
    .syn_seen       (syn_seen),
    .arp_seen       (arp_seen),
    .new_source     (new_source),
    .table_full     (table_full),
    .syn_total      (syn_total),
    .arp_total      (arp_total),
    .distinct_total (distinct_total)
  );

  // records enter the queue only when it has room
  assert property (@(posedge clk) disable iff (rst) front_push |-> !q_full)
    else $error("frame record pushed into a full queue");

  // a stored or rejected source belongs to a syn frame
  assert property (@(posedge clk) disable iff (rst)
    (!empty && (new_source || table_full)) |-> syn_seen)
    else $error("source flag on a frame that is not syn");

  // a source is either stored or rejected, never both
  assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(new_source && table_full))
    else $error("new source and table full together");

  // ipv4 syn and arp are exclusive ether types
  assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(syn_seen && arp_seen))
    else $error("frame classified as both syn and arp");

endmodule
`default_nettype wire

// ----- hw/rtl/sst_front.sv -----
// header parser: captures fields byte by byte and classifies each frame
`default_nettype none
module sst_front
  import sst_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       beat,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output frame_rec_t      rec,
  output logic            rec_push
);

  logic [POS_W-1:0] pos;
  logic [15:0]      frame_type;
  logic [3:0]       header_words;
  logic [7:0]       protocol_number;
  logic [31:0]      source_address;
  logic [5:0]       flag_bits;
  logic             flags_captured;

  logic [POS_W-1:0] pos_next;
  logic [15:0]      frame_type_next;
  logic [3:0]       header_words_next;
  logic [7:0]       protocol_number_next;
  logic [31:0]      source_address_next;
  logic [5:0]       flag_bits_next;
  logic             flags_captured_next;
  logic [POS_W-1:0] flags_pos;

  // field capture at fixed and ihl-dependent offsets for the current byte
  always_comb begin
    flags_pos            = POS_FLAGS_BASE + {1'b0, header_words, 2'b00};
    pos_next             = (pos == POS_MAX) ? pos : pos + 7'd1;
    frame_type_next      = frame_type;
    header_words_next    = header_words;
    protocol_number_next = protocol_number;
    source_address_next  = source_address;
    flag_bits_next       = flag_bits;
    flags_captured_next  = flags_captured;
    if (pos == POS_TYPE_HI || pos == POS_TYPE_LO) begin
      frame_type_next = {frame_type[7:0], data_byte};
    end
    if (pos == POS_IHL) begin
      header_words_next = data_byte[3:0];
    end
    if (pos == POS_PROTO) begin
      protocol_number_next = data_byte;
    end
    if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST) begin
      source_address_next = {source_address[23:0], data_byte};
    end
    // ihl of at least five places the flags past the ihl byte
    if (header_words >= IHL_MIN && pos == flags_pos) begin
      flag_bits_next      = data_byte[5:0];
      flags_captured_next = 1'b1;
    end
  end

  // frame classification on the last beat
  always_comb begin
    rec.arp  = (pos >= POS_TYPE_LO) && (frame_type_next == TYPE_ARP);
    rec.syn  = flags_captured_next && (frame_type_next == TYPE_IPV4) &&
               (protocol_number_next == PROTO_TCP) &&
               (flag_bits_next == FLAGS_SYN_ONLY);
    rec.src  = source_address_next;
    rec_push = beat && last_byte;
  end

  // frame state, cleared on reset and after each last beat
  always_ff @(posedge clk) begin
    if (rst || (beat && last_byte)) begin
      pos             <= '0;
      frame_type      <= '0;
      header_words    <= '0;
      protocol_number <= '0;
      source_address  <= '0;
      flag_bits       <= '0;
      flags_captured  <= 1'b0;
    end else if (beat) begin
      pos             <= pos_next;
      frame_type      <= frame_type_next;
      header_words    <= header_words_next;
      protocol_number <= protocol_number_next;
      source_address  <= source_address_next;
      flag_bits       <= flag_bits_next;
      flags_captured  <= flags_captured_next;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/sst_queue.sv -----
// short queue of classified frame records between front and back
`default_nettype none
module sst_queue
  import sst_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire frame_rec_t push_rec,
  output logic            full,
  input  wire logic       pop,
  output frame_rec_t      head_rec,
  output logic            empty
);

  frame_rec_t          slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   level;

  // status
  always_comb begin
    full     = (level == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    empty    = (level == '0);
    head_rec = slots[rd_ptr];
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/sst_back.sv -----
// lookup side: source table search, counters and result register
`default_nettype none
module sst_back
  import sst_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        rec_empty,
  input  wire frame_rec_t  rec_in,
  output logic             rec_pop,
  output logic             empty,
  input  wire logic        pop,
  output logic             syn_seen,
  output logic             arp_seen,
  output logic             new_source,
  output logic             table_full,
  output logic [31:0]      syn_total,
  output logic [31:0]      arp_total,
  output logic [6:0]       distinct_total
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]    state;
  frame_rec_t    rec;
  logic [CW-1:0] idx;
  logic          pend;
  logic          is_new;
  logic [CW-1:0] entry_count;
  logic [31:0]   syn_counter;
  logic [31:0]   arp_counter;
  logic          out_valid;

  logic [31:0]   addr_table [TABLE_DEPTH];
  logic [31:0]   rd_data;
  logic          tbl_we;

  logic          hit;
  logic          miss;
  logic          issue;
  logic          slot_free;
  logic          has_room;
  logic          store;
  logic [CW-1:0] entry_count_next;
  logic [31:0]   syn_counter_next;
  logic [31:0]   arp_counter_next;

  // scan and result decisions
  always_comb begin
    hit              = pend && (rd_data == rec.src);
    miss             = !pend && (idx == entry_count);
    issue            = (idx < entry_count);
    slot_free        = !out_valid || pop;
    has_room         = (entry_count < CW'(TABLE_DEPTH));
    store            = rec.syn && is_new && has_room;
    rec_pop          = (state == ST_IDLE) && !rec_empty;
    tbl_we           = (state == ST_EMIT) && slot_free && store;
    entry_count_next = store ? entry_count + 1'b1 : entry_count;
    syn_counter_next = syn_counter + {31'd0, rec.syn};
    arp_counter_next = arp_counter + {31'd0, rec.arp};
    empty            = !out_valid;
  end

  // address table, one read and one write port
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      addr_table[entry_count[AW-1:0]] <= rec.src;
    end
    rd_data <= addr_table[idx[AW-1:0]];
  end

  // record latch and scan bookkeeping
  always_ff @(posedge clk) begin
    if (rec_pop) begin
      rec <= rec_in;
    end
    if (state == ST_IDLE) begin
      idx    <= '0;
      pend   <= 1'b0;
      is_new <= 1'b0;
    end else if (state == ST_SCAN) begin
      if (hit) begin
        is_new <= 1'b0;
      end else if (miss) begin
        is_new <= 1'b1;
      end else begin
        pend <= issue;
        if (issue) begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  // control sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (rec_pop) begin
            state <= rec_in.syn ? ST_SCAN : ST_EMIT;
          end
        end
        ST_SCAN: begin
          if (hit || miss) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // running totals
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      syn_counter <= '0;
      arp_counter <= '0;
    end else if (state == ST_EMIT && slot_free) begin
      entry_count <= entry_count_next;
      syn_counter <= syn_counter_next;
      arp_counter <= arp_counter_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && slot_free) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && slot_free) begin
      syn_seen       <= rec.syn;
      arp_seen       <= rec.arp;
      new_source     <= store;
      table_full     <= rec.syn && is_new && !has_room;
      syn_total      <= syn_counter_next;
      arp_total      <= arp_counter_next;
      distinct_total <= 7'(entry_count_next);
    end
  end

endmodule
`default_nettype wire
